FILE: rtl/dst_pkg.sv
// Shared constants and types for the diamond-square terrain generator.
`default_nettype none

package dst_pkg;

    // Default build parameters
    localparam int MAX_LEVELS_DEF   = 8;
    localparam int HEIGHT_WIDTH_DEF = 24;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Register file
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVELS_W    = 4;
    localparam int RANGE_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LEVELS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE  = 1'b1;

    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 4'd8;
    localparam logic [RANGE_W-1:0]  RANGE_RESET  = 16'd256;

    // Reported coordinate width and rounded noise width
    localparam int COORD_W = 9;
    localparam int NOISE_W = RANGE_W + 2;

    // Per-point control handed from the cursor walker to the datapath
    typedef struct packed {
        logic [3:0] nb_ok;       // neighbor exists and must be read
        logic       div3;        // mean over three neighbors
        logic       last_point;  // this point completes the map
    } walk_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/diamond_square_terrain.sv
// Diamond-square height map generator: top level with grid memory and datapath.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   input     | in_valid / in_stall  | random_sample
//   result    | out_valid / out_stall| point_x, point_y, height, last_point
//   config    | cfg_write            | cfg_index, cfg_data
//
// A corner point skips the reads; every other point first makes four reads of
// the single read port of the grid memory. Every point then passes a stage for
// the divide by three (reciprocal multiply) and a stage for rounding, saturation and write-back.
// Reset clears control only; the grid memory is not cleared, as no point is read
// before it is written in the same map. A result waiting under out_stall holds
// the next request in its final stage; no further request is taken meanwhile.
`default_nettype none

module diamond_square_terrain #(
    parameter int MAX_LEVELS   = dst_pkg::MAX_LEVELS_DEF,
    parameter int HEIGHT_WIDTH = dst_pkg::HEIGHT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = dst_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [dst_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dst_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]    random_sample,
    input  logic                              in_valid,
    output logic                              in_stall,
    output logic [dst_pkg::COORD_W-1:0]       point_x,
    output logic [dst_pkg::COORD_W-1:0]       point_y,
    output logic signed [HEIGHT_WIDTH-1:0]    height,
    output logic                              last_point,
    output logic                              out_valid,
    input  logic                              out_stall
);
    import dst_pkg::*;

    localparam int CW       = MAX_LEVELS + 1;
    localparam int SIDE_MAX = (1 << MAX_LEVELS) + 1;
    localparam int DEPTH    = SIDE_MAX * SIDE_MAX;
    localparam int AW       = $clog2(DEPTH);
    localparam int HW       = HEIGHT_WIDTH;
    localparam int SUM_W    = HW + 2;
    localparam int HSUM_W   = HW + 3;
    localparam int PW       = SAMPLE_WIDTH + RANGE_W + 1;
    localparam int DP_W     = 2 * SUM_W;

    // floor(x/3) = (x * ceil(2^(SUM_W+1)/3)) >> (SUM_W+1) for x below 2^SUM_W
    localparam logic [SUM_W-1:0] DIV_MAGIC =
        SUM_W'(((64'd1 << (SUM_W + 1)) + 64'd2) / 64'd3);
    localparam logic [SUM_W-1:0] DIV_BIAS = SUM_W'(3) << (HW - 1);
    localparam logic signed [HSUM_W-1:0] MEAN_BIAS = HSUM_W'(1) << (HW - 1);
    localparam logic signed [PW-1:0] NOISE_HALF = PW'(1) << (SAMPLE_WIDTH - 2);
    localparam logic signed [HSUM_W-1:0] HMAX = HSUM_W'((64'sd1 <<< (HW - 1)) - 64'sd1);
    localparam logic signed [HSUM_W-1:0] HMIN = HSUM_W'(-(64'sd1 <<< (HW - 1)));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FIN
    } state_t;

    // Walker outputs
    logic [CW-1:0]      walk_x, walk_y;
    logic [AW-1:0]      walk_pt_addr;
    logic [AW-1:0]      walk_nb_addr [4];
    walk_ctl_t          walk_ctl;
    logic [RANGE_W-1:0] walk_range;
    logic               accept;

    dst_walk #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pt_x      (walk_x),
        .pt_y      (walk_y),
        .pt_addr   (walk_pt_addr),
        .nb_addr   (walk_nb_addr),
        .ctl       (walk_ctl),
        .range     (walk_range)
    );

    // Request state
    state_t                    state_reg;
    logic [1:0]                rd_idx_reg;
    logic [AW-1:0]             nb_addr_reg [4];
    logic [3:0]                nb_ok_reg;
    logic                      div3_reg;
    logic                      last_reg;
    logic [CW-1:0]             pt_x_reg, pt_y_reg;
    logic [AW-1:0]             pt_addr_reg;
    logic signed [PW-1:0]      noise_prod_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [NOISE_W-1:0] noise_reg;
    logic signed [HW-1:0]      mean4_reg;
    logic [DP_W-1:0]           div_prod_reg;

    // Result register
    logic                      out_valid_reg;
    logic [COORD_W-1:0]        point_x_reg, point_y_reg;
    logic signed [HW-1:0]      height_reg;
    logic                      last_point_reg;

    // Grid memory
    logic signed [HW-1:0]      grid_mem [DEPTH];
    logic signed [HW-1:0]      rdata_reg;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;
    logic                      out_free;

    // Datapath
    logic [SUM_W-1:0]          div_u;
    logic [HW:0]               div_q;
    logic signed [HSUM_W-1:0]  mean_w;
    logic signed [HSUM_W-1:0]  h_w;
    logic signed [HW-1:0]      h_sat;

    // Input handshake: one request at a time
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // First neighbor is read in the accept cycle, the rest one per cycle
    assign rd_addr = (state_reg == ST_IDLE) ? walk_nb_addr[0]
                                            : nb_addr_reg[rd_idx_reg + 2'd1];

    assign out_free = !out_valid_reg || !out_stall;
    assign mem_we   = (state_reg == ST_FIN) && out_free;

    // Divide-by-three operand, biased positive
    assign div_u = $unsigned(sum_reg) + SUM_W'(1) + DIV_BIAS;
    assign div_q = div_prod_reg[DP_W-1 -: HW + 1];

    // Mean plus noise, saturated
    always_comb
    begin
        if (div3_reg)
            mean_w = $signed(HSUM_W'(div_q)) - MEAN_BIAS;
        else
            mean_w = HSUM_W'(mean4_reg);
        h_w = mean_w + HSUM_W'(noise_reg);
        if (h_w > HMAX)
            h_sat = HW'(HMAX);
        else if (h_w < HMIN)
            h_sat = HW'(HMIN);
        else
            h_sat = HW'(h_w);
    end

    // Memory read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= grid_mem[rd_addr];
    end

    // Memory write port; writes land before the next request reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[pt_addr_reg] <= h_sat;
    end

    // Request sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            nb_ok_reg      <= '0;
            div3_reg       <= 1'b0;
            last_reg       <= 1'b0;
            last_point_reg <= 1'b0;
        end
        else
        begin
            // a new result from the write-back stage takes precedence
            if (out_valid_reg && !out_stall && !mem_we)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        nb_addr_reg    <= walk_nb_addr;
                        nb_ok_reg      <= walk_ctl.nb_ok;
                        div3_reg       <= walk_ctl.div3;
                        last_reg       <= walk_ctl.last_point;
                        pt_x_reg       <= walk_x;
                        pt_y_reg       <= walk_y;
                        pt_addr_reg    <= walk_pt_addr;
                        noise_prod_reg <= PW'(random_sample) * $signed({1'b0, walk_range});
                        sum_reg        <= '0;
                        rd_idx_reg     <= '0;
                        // corners have no neighbors to read
                        if (walk_ctl.nb_ok == 4'b0000)
                            state_reg <= ST_DIV;
                        else
                            state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (nb_ok_reg[rd_idx_reg])
                        sum_reg <= sum_reg + SUM_W'(rdata_reg);
                    rd_idx_reg <= rd_idx_reg + 2'd1;
                    if (rd_idx_reg == 2'd3)
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_prod_reg <= DP_W'(div_u) * DP_W'(DIV_MAGIC);
                    mean4_reg    <= HW'((sum_reg + $signed(SUM_W'(2))) >>> 2);
                    noise_reg    <= NOISE_W'((noise_prod_reg + NOISE_HALF)
                                             >>> (SAMPLE_WIDTH - 1));
                    state_reg    <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        point_x_reg    <= COORD_W'(pt_x_reg);
                        point_y_reg    <= COORD_W'(pt_y_reg);
                        height_reg     <= h_sat;
                        last_point_reg <= last_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign height     = height_reg;
    assign last_point = last_point_reg;

`ifndef ASSERT_OFF
    // A result appears only out of the write-back stage
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside write-back stage");

    // Corners skip the read phase, all other points go through it
    a_corner_skips_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg == ST_READ) == (nb_ok_reg != 4'b0000)))
        else $error("read phase does not match neighbor set");

    // Three-way mean only with exactly three neighbors
    a_div3_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div3_reg) |-> ($countones(nb_ok_reg) == 3))
        else $error("divide by three with wrong neighbor count");
`endif

endmodule

`default_nettype wire

FILE: rtl/dst_walk.sv
// Grid cursor walker: point order, neighbor addresses, level and range tracking.
`default_nettype none

module dst_walk #(
    parameter int MAX_LEVELS = dst_pkg::MAX_LEVELS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [dst_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [dst_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   advance,
    output logic [MAX_LEVELS:0]                    pt_x,
    output logic [MAX_LEVELS:0]                    pt_y,
    output logic [$clog2(((1 << MAX_LEVELS) + 1) * ((1 << MAX_LEVELS) + 1))-1:0] pt_addr,
    output logic [$clog2(((1 << MAX_LEVELS) + 1) * ((1 << MAX_LEVELS) + 1))-1:0] nb_addr [4],
    output dst_pkg::walk_ctl_t                     ctl,
    output logic [dst_pkg::RANGE_W-1:0]            range
);
    import dst_pkg::*;

    localparam int CW       = MAX_LEVELS + 1;
    localparam int EW       = CW + 1;
    localparam int SIDE_MAX = (1 << MAX_LEVELS) + 1;
    localparam int AW       = $clog2(SIDE_MAX * SIDE_MAX);

    typedef enum logic [1:0] {
        PH_CORNER,
        PH_DIAMOND,
        PH_SQUARE
    } phase_t;

    // Grid side minus one for a levels value, clamped to the legal range
    function automatic logic [CW-1:0] last_of(input logic [LEVELS_W-1:0] lv);
        logic [LEVELS_W-1:0] c;
        c = lv;
        if (c == '0)
            c = LEVELS_W'(1);
        if (c > LEVELS_W'(MAX_LEVELS))
            c = LEVELS_W'(MAX_LEVELS);
        return CW'(1) << c;
    endfunction

    // Row-major address, row length fixed at the largest side
    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(x) * AW'(SIDE_MAX) + AW'(y);
    endfunction

    logic [LEVELS_W-1:0] levels_reg, levels_next;
    logic [RANGE_W-1:0]  init_range_reg, init_range_next;
    logic [RANGE_W-1:0]  range_reg, range_next;
    logic [CW-1:0]       cx_reg, cx_next;
    logic [CW-1:0]       cy_reg, cy_next;
    logic [CW-1:0]       step_reg, step_next;
    phase_t              phase_reg, phase_next;

    logic [CW-1:0] last_w;
    logic [EW-1:0] size_w;
    logic [CW-1:0] half_w;
    logic [CW-1:0] nbx [4];
    logic [CW-1:0] nby [4];
    logic [3:0]    ok_w;
    logic [EW-1:0] ny_w;
    logic [EW-1:0] nx_w;
    logic [CW-1:0] new_last_w;

    assign last_w = last_of(levels_reg);
    assign size_w = EW'(last_w) + EW'(1);
    assign half_w = step_reg >> 1;

    // Neighbor coordinates for the current point
    always_comb
    begin
        ok_w = 4'b0000;
        pt_x = cx_reg;
        pt_y = cy_reg;
        for (int k = 0; k < 4; k++)
        begin
            nbx[k] = '0;
            nby[k] = '0;
        end
        case (phase_reg)
            PH_DIAMOND:
            begin
                ok_w   = 4'b1111;
                pt_x   = cx_reg + half_w;
                pt_y   = cy_reg + half_w;
                nbx[0] = cx_reg;
                nby[0] = cy_reg;
                nbx[1] = cx_reg + step_reg;
                nby[1] = cy_reg;
                nbx[2] = cx_reg;
                nby[2] = cy_reg + step_reg;
                nbx[3] = cx_reg + step_reg;
                nby[3] = cy_reg + step_reg;
            end
            PH_SQUARE:
            begin
                ok_w[0] = (cx_reg >= half_w);
                ok_w[1] = ((EW'(cx_reg) + EW'(half_w)) < size_w);
                ok_w[2] = (cy_reg >= half_w);
                ok_w[3] = ((EW'(cy_reg) + EW'(half_w)) < size_w);
                if (ok_w[0])
                begin
                    nbx[0] = cx_reg - half_w;
                    nby[0] = cy_reg;
                end
                if (ok_w[1])
                begin
                    nbx[1] = cx_reg + half_w;
                    nby[1] = cy_reg;
                end
                if (ok_w[2])
                begin
                    nbx[2] = cx_reg;
                    nby[2] = cy_reg - half_w;
                end
                if (ok_w[3])
                begin
                    nbx[3] = cx_reg;
                    nby[3] = cy_reg + half_w;
                end
            end
            default:
            begin
                ok_w = 4'b0000;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            nb_addr[k] = addr_of(nbx[k], nby[k]);
    end

    assign pt_addr = addr_of(pt_x, pt_y);
    assign range   = range_reg;

    // Cursor advance; a register write restarts the map
    always_comb
    begin
        levels_next     = levels_reg;
        init_range_next = init_range_reg;
        range_next      = range_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        ny_w            = EW'(cy_reg) + EW'(step_reg);
        nx_w            = '0;
        new_last_w      = last_w;
        ctl.nb_ok       = ok_w;
        ctl.div3        = (phase_reg == PH_SQUARE) && (ok_w != 4'b1111);
        ctl.last_point  = 1'b0;

        if (cfg_write)
        begin
            if (cfg_index == REG_LEVELS)
            begin
                levels_next = cfg_data[LEVELS_W-1:0];
                new_last_w  = last_of(cfg_data[LEVELS_W-1:0]);
            end
            else
            begin
                init_range_next = cfg_data[RANGE_W-1:0];
            end
            cx_next    = '0;
            cy_next    = '0;
            step_next  = new_last_w;
            phase_next = PH_CORNER;
            range_next = init_range_next;
        end
        else
        begin
            case (phase_reg)
                PH_DIAMOND:
                begin
                    nx_w = EW'(cx_reg) + EW'(step_reg);
                    if (advance)
                    begin
                        if (ny_w >= EW'(last_w))
                        begin
                            cy_next = '0;
                            if (nx_w >= EW'(last_w))
                            begin
                                phase_next = PH_SQUARE;
                                cx_next    = '0;
                                cy_next    = half_w;
                            end
                            else
                            begin
                                cx_next = nx_w[CW-1:0];
                            end
                        end
                        else
                        begin
                            cy_next = ny_w[CW-1:0];
                        end
                    end
                end
                PH_SQUARE:
                begin
                    nx_w = EW'(cx_reg) + EW'(half_w);
                    ctl.last_point = (ny_w >= size_w) && (nx_w >= size_w)
                                     && (step_reg == CW'(2));
                    if (advance)
                    begin
                        if (ny_w >= size_w)
                        begin
                            if (nx_w >= size_w)
                            begin
                                if (step_reg > CW'(2))
                                begin
                                    range_next = range_reg >> 1;
                                    step_next  = half_w;
                                    phase_next = PH_DIAMOND;
                                    cx_next    = '0;
                                    cy_next    = '0;
                                end
                                else
                                begin
                                    // map done: start over
                                    range_next = init_range_reg;
                                    step_next  = last_w;
                                    phase_next = PH_CORNER;
                                    cx_next    = '0;
                                    cy_next    = '0;
                                end
                            end
                            else
                            begin
                                cx_next = nx_w[CW-1:0];
                                cy_next = CW'(nx_w + EW'(half_w)) & (step_reg - CW'(1));
                            end
                        end
                        else
                        begin
                            cy_next = ny_w[CW-1:0];
                        end
                    end
                end
                default:
                begin
                    // corner order: (0,0) (0,S) (S,0) (S,S)
                    if (advance)
                    begin
                        if (cx_reg == '0 && cy_reg == '0)
                            cy_next = last_w;
                        else if (cx_reg == '0)
                        begin
                            cx_next = last_w;
                            cy_next = '0;
                        end
                        else if (cy_reg == '0)
                            cy_next = last_w;
                        else
                        begin
                            phase_next = PH_DIAMOND;
                            cx_next    = '0;
                            cy_next    = '0;
                        end
                    end
                end
            endcase
        end
    end

    // Walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg     <= LEVELS_RESET;
            init_range_reg <= RANGE_RESET;
            range_reg      <= RANGE_RESET;
            cx_reg         <= '0;
            cy_reg         <= '0;
            step_reg       <= last_of(LEVELS_RESET);
            phase_reg      <= PH_CORNER;
        end
        else
        begin
            levels_reg     <= levels_next;
            init_range_reg <= init_range_next;
            range_reg      <= range_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            step_reg       <= step_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

`default_nettype wire
